// ===== rtl/core/bcs_pkg.sv =====
// Package: shared types and constants of the breath cycle sequencer.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int PHASE_TIMER_BITS = 32;

  typedef enum logic [1:0] {
    PH_FILL_TANK   = 2'd0,
    PH_FILL_ADJUST = 2'd1,
    PH_INHALE      = 2'd2,
    PH_EXHALE      = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ALM_NONE      = 3'd0,
    ALM_PEAK_HIGH = 3'd1,
    ALM_PEAK_LOW  = 3'd2,
    ALM_SUPPLY    = 3'd3,
    ALM_PEEP_HIGH = 3'd4
  } alarm_code_t;

  typedef enum logic [2:0] {
    REG_BPM_MIN   = 3'd0,
    REG_BPM_MAX   = 3'd1,
    REG_TIDAL_MIN = 3'd2,
    REG_TIDAL_MAX = 3'd3,
    REG_FILL_MS   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  localparam logic [15:0] RATE_NUMERATOR = 16'd60000;
  localparam logic [6:0]  RATE_MAX       = 7'd99;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic signed [15:0] tank_pressure;
    logic signed [15:0] patient_pressure;
    logic signed [15:0] supply_pressure;
    logic [7:0] bpm_knob;
    logic [7:0] tidal_knob;
    logic [7:0] high_airway_knob;
    logic [7:0] low_airway_knob;
    logic [7:0] peep_knob;
  } tick_t;

  typedef struct packed {
    logic [1:0] phase;
    logic tank_valve_open;
    logic outlet_valve_open;
    logic patient_valve_open;
    logic alarm_on;
    logic [2:0] alarm_code;
    logic [15:0] peak_cmh2o;
    logic [15:0] peep_cmh2o;
    logic [6:0] measured_bpm;
    logic [7:0] set_bpm;
    logic [15:0] set_tidal_ml;
  } result_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic eval;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } status_t;

endpackage

// ===== rtl/core/bcs_if.sv =====
// Interfaces: tick, result and configuration channels.
`timescale 1ns / 1ps
interface bcs_tick_if;
  import bcs_pkg::*;
  logic valid;
  logic ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcs_result_if;
  import bcs_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcs_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/bcs_ctrl.sv =====
// Controller: sequences load, conversion, evaluation, rate division and delivery.
`timescale 1ns / 1ps
module bcs_ctrl import bcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  ctrl_state_t state, state_next;

  // Accept a new request when idle and the output slot is free or draining
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_CONV;
      ST_CONV: state_next = ST_EVAL;
      ST_EVAL: state_next = status.div_needed ? ST_DIV : ST_DONE;
      ST_DIV:  if (status.div_last) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.load = in_valid && in_ready;
      ST_CONV: cmd.conv = 1'b1;
      ST_EVAL: cmd.eval = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Result is produced only from the delivery step
  a_finish_from_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish did not raise result valid");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_CONV) else $error("load did not start conversion");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_last) |=> state == ST_DONE)
    else $error("division did not end");

endmodule

// ===== rtl/core/bcs_dp.sv =====
// Datapath: phase state, timers, pressure conversion, alarms and rate divider.
`timescale 1ns / 1ps
module bcs_dp import bcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tick_t     tick,
  input  cmd_t      cmd,
  output status_t   status,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  output result_t   result
);

  localparam logic [PHASE_TIMER_BITS-1:0] TMAX = '1;

  // Configuration
  logic [7:0]  bpm_min, bpm_max, tid_min, tid_max;
  logic [15:0] fill_ms;

  // Architectural state
  phase_t      phase;
  logic [PHASE_TIMER_BITS-1:0] time_in_phase;
  logic [15:0] inhale_lim, exhale_lim, adjust_lim, tank_target;
  logic [7:0]  max_cm, low_cm, peep_cm;
  logic [15:0] peak_now, peak_prev, peep_now;
  logic [31:0] since_ms;
  logic [6:0]  rate_now;
  logic        alarm_on;
  logic [2:0]  alarm_code;
  logic [2:0]  valves;
  logic [7:0]  set_bpm;
  logic [15:0] set_tidal;

  // Captured request and pipeline values
  tick_t       t;
  logic [27:0] cm_x;
  logic [42:0] cm_mul;
  logic [15:0] cm_val;
  logic signed [40:0] hi_lhs, hi_rhs;

  // Divider
  logic [31:0] div_den;
  logic [15:0] div_quo;
  logic [31:0] div_rem;
  logic [4:0]  div_cnt;

  assign status.div_last   = (div_cnt == 5'd0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bpm_min <= 8'd12; bpm_max <= 8'd20; tid_min <= 8'd0; tid_max <= 8'd6;
      fill_ms <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPM_MIN:   bpm_min <= cfg_wdata[7:0];
        REG_BPM_MAX:   bpm_max <= cfg_wdata[7:0];
        REG_TIDAL_MIN: tid_min <= cfg_wdata[7:0];
        REG_TIDAL_MAX: tid_max <= cfg_wdata[7:0];
        REG_FILL_MS:   fill_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Combinational evaluation of one tick
  logic [15:0] cm;
  logic [32:0] since_sum;
  logic [PHASE_TIMER_BITS:0] tip_sum;
  logic [31:0] since_n;
  logic [PHASE_TIMER_BITS-1:0] tip_n;
  logic [15:0] peak_n, peep_n, limit;
  logic        adv, hi, enter_inhale;
  logic [7:0]  d;
  logic [15:0] ci, ce;
  logic [31:0] x_since;

  always_comb begin
    cm = (t.patient_pressure > 16'sd0) ? cm_val : 16'd0;
    since_sum = {1'b0, since_ms} + 33'(t.elapsed_ms);
    since_n = since_sum[32] ? 32'hFFFF_FFFF : since_sum[31:0];
    tip_sum = {1'b0, time_in_phase} + (PHASE_TIMER_BITS+1)'(t.elapsed_ms);
    tip_n = tip_sum[PHASE_TIMER_BITS] ? TMAX : tip_sum[PHASE_TIMER_BITS-1:0];
    peak_n = (cm > peak_now) ? cm : peak_now;
    peep_n = (peep_now != 16'd0 && cm >= peep_now) ? peep_now : cm;
    unique case (phase)
      PH_FILL_TANK:   limit = fill_ms;
      PH_FILL_ADJUST: limit = adjust_lim;
      PH_INHALE:      limit = inhale_lim;
      default:        limit = exhale_lim;
    endcase
    hi = hi_lhs >= hi_rhs;
    d = t.bpm_knob - bpm_min;
    ci = 16'((17'd125 * 17'(d) + 17'd1) >> 1);
    ce = 16'((18'd375 * 18'(d) + 18'd1) >> 1);
    adv = (tip_n >= PHASE_TIMER_BITS'(limit)) ||
          (phase == PH_FILL_TANK && t.tank_pressure >= $signed({1'b0, tank_target})) ||
          (phase == PH_INHALE && hi);
    enter_inhale = adv && (phase == PH_FILL_ADJUST);
    x_since = since_n;
  end

  // Run the rate divider when an inhale starts after a nonzero interval
  assign status.div_needed = enter_inhale && (x_since != 32'd0);

  // Divide by 25600 as a shift by 8 and a reciprocal multiply for 100
  assign cm_mul = 43'(cm_x[27:8]) * 43'd1342178;

  // Capture the request, then form scaled cmH2O and peak-high operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t <= tick;
      cm_x <= 28'(tick.patient_pressure[14:0]) * 28'd7037 + 28'd12800;
    end
    if (cmd.conv) begin
      cm_val <= cm_mul[42:27];
      hi_lhs <= 41'(t.patient_pressure) * 41'sd70307;
      hi_rhs <= $signed({33'd0, max_cm}) * 41'sd256000;
    end
  end

  // Evaluation and division steps: update state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FILL_TANK; time_in_phase <= '0;
      inhale_lim <= 16'd1500; exhale_lim <= 16'd3000; adjust_lim <= 16'd300;
      tank_target <= 16'd1280; max_cm <= 8'd50; low_cm <= 8'd0; peep_cm <= 8'd20;
      peak_now <= '0; peak_prev <= 16'd20; peep_now <= '0; since_ms <= '0;
      rate_now <= '0; alarm_on <= 1'b0; alarm_code <= ALM_NONE; valves <= '0;
      set_bpm <= '0; set_tidal <= '0; div_cnt <= '0;
    end else if (cmd.eval) begin
      since_ms <= enter_inhale ? '0 : x_since;
      peak_now <= enter_inhale ? '0 : peak_n;
      peep_now <= enter_inhale ? '0 : peep_n;
      time_in_phase <= adv ? '0 : tip_n;
      if (adv) begin
        phase <= phase_t'(phase + 2'd1);
        unique case (phase)
          PH_EXHALE: begin
            valves <= 3'b011;
            if (bpm_min <= t.bpm_knob && t.bpm_knob <= bpm_max) begin
              inhale_lim <= (ci >= 16'd1500) ? 16'd0 : 16'd1500 - ci;
              exhale_lim <= (ce >= 16'd3000) ? 16'd0 : 16'd3000 - ce;
              set_bpm <= t.bpm_knob;
            end
            if (tid_min <= t.tidal_knob && t.tidal_knob <= tid_max) begin
              adjust_lim <= 16'(16'd50 * 16'(t.tidal_knob));
              tank_target <= 16'(16'd1280 + 16'd224 * 16'(t.tidal_knob));
              set_tidal <= 16'(16'd400 + 16'd100 * 16'(t.tidal_knob));
            end
            max_cm <= t.high_airway_knob; low_cm <= t.low_airway_knob;
            peep_cm <= t.peep_knob;
          end
          PH_FILL_TANK: valves <= 3'b011;
          PH_FILL_ADJUST: begin
            valves <= 3'b100; peak_prev <= peak_n;
            if (x_since == 32'd0) rate_now <= RATE_MAX;
            else begin
              div_den <= x_since; div_cnt <= 5'd15;
              div_rem <= '0; div_quo <= RATE_NUMERATOR;
            end
          end
          default: valves <= 3'b010;
        endcase
      end else if (phase == PH_FILL_ADJUST &&
                   t.tank_pressure >= $signed({1'b0, tank_target})) begin
        valves[0] <= 1'b0;
      end
      // Alarm checks
      if (tip_n < PHASE_TIMER_BITS'(limit)) begin
        if (phase == PH_FILL_TANK && t.supply_pressure <= 16'sd0) begin
          alarm_on <= 1'b1; alarm_code <= ALM_SUPPLY;
        end else if (phase == PH_INHALE) begin
          if (peep_n >= 16'(peep_cm) && peep_n != 16'd0) begin
            alarm_on <= 1'b1; alarm_code <= ALM_PEEP_HIGH;
          end else if (peak_prev <= 16'(low_cm)) begin
            alarm_on <= 1'b1; alarm_code <= ALM_PEAK_LOW;
          end else if (hi) begin
            alarm_on <= 1'b1; alarm_code <= ALM_PEAK_HIGH;
          end else if (peep_n < 16'(peep_cm) && t.supply_pressure > 16'sd0) begin
            alarm_on <= 1'b0; alarm_code <= ALM_NONE;
          end
        end
      end
    end else if (cmd.div_step) begin
      // Restoring division, one quotient bit per cycle
      logic [32:0] r;
      r = {div_rem, div_quo[15]};
      if (r >= {1'b0, div_den}) begin
        div_rem <= 32'(r - {1'b0, div_den}); div_quo <= {div_quo[14:0], 1'b1};
      end else begin
        div_rem <= r[31:0]; div_quo <= {div_quo[14:0], 1'b0};
      end
      div_cnt <= div_cnt - 5'd1;
      if (div_cnt == 5'd0) begin
        rate_now <= (div_quo[14:0] != 15'd0 && {div_quo[14:0], r >= {1'b0, div_den}} > 16'd99)
                    ? RATE_MAX
                    : 7'({div_quo[14:0], r >= {1'b0, div_den}});
      end
    end
  end

  assign result.phase = phase;
  assign result.tank_valve_open = valves[0];
  assign result.outlet_valve_open = valves[1];
  assign result.patient_valve_open = valves[2];
  assign result.alarm_on = alarm_on;
  assign result.alarm_code = alarm_code;
  assign result.peak_cmh2o = peak_now;
  assign result.peep_cmh2o = peep_now;
  assign result.measured_bpm = rate_now;
  assign result.set_bpm = set_bpm;
  assign result.set_tidal_ml = set_tidal;

  a_rate_sat: assert property (@(posedge clk) disable iff (rst)
    rate_now <= RATE_MAX) else $error("rate above saturation");
  a_inhale_valves: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_INHALE) |-> valves == 3'b100) else $error("inhale valves wrong");
  a_exhale_valves: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXHALE) |-> valves == 3'b010) else $error("exhale valves wrong");

endmodule

// ===== rtl/core/breath_cycle_sequencer.sv =====
// Top level: breath cycle sequencer with tick, result and configuration channels.
//
//  channel  dir  handshake     payload
//  tick     in   valid/ready   elapsed time, pressures, knobs
//  result   out  valid/ready   phase, valves, alarm, pressures, rates
//  cfg      in   valid/ready   index, wdata
//
// A tick passes conversion, evaluation, the 16-step rate divider when an inhale
// starts after a nonzero interval, and delivery; no new tick is taken meanwhile.
// Synchronous active-high reset restores sequencer state and register defaults.
// A finished result waits in the output register; the next tick is taken
// in the cycle the result is taken. Configuration writes are always ready.
`timescale 1ns / 1ps
module breath_cycle_sequencer import bcs_pkg::*; (
  input logic clk,
  input logic rst,
  bcs_tick_if.sink     tick,
  bcs_result_if.source result,
  bcs_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;
  result_t res;
  logic    out_valid;

  bcs_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(tick.valid), .in_ready(tick.ready),
    .out_valid, .out_ready(result.ready),
    .status, .cmd
  );

  bcs_dp u_dp (
    .clk, .rst, .tick(tick.data), .cmd, .status,
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata),
    .result(res)
  );

  assign cfg.ready = 1'b1;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
    if (cmd.finish) result.data <= res;
  end

  assign result.valid = out_valid;

endmodule

// ===== bench/tb_breath_cycle_sequencer.sv =====
// Testbench for the breath cycle sequencer: directed table, then random ticks against a predictor.
`timescale 1ns / 1ps
module tb_breath_cycle_sequencer;
  import bcs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcs_tick_if   tick_ch();
  bcs_result_if res_ch();
  bcs_cfg_if    cfg_ch();

  breath_cycle_sequencer u_dut (
    .clk(clk), .rst(rst), .tick(tick_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  always #6 clk = ~clk;

  // Predictor copy of configuration and state
  logic [7:0]  m_bpm_min, m_bpm_max, m_tid_min, m_tid_max;
  logic [15:0] m_fill_ms;
  phase_t      m_phase;
  logic [31:0] m_tip, m_since;
  logic [31:0] m_inh_lim, m_exh_lim, m_adj_lim, m_target;
  logic [7:0]  m_max_cm, m_low_cm, m_peep_lim;
  logic [31:0] m_peak, m_peak_prev, m_peep;
  logic [6:0]  m_rate;
  logic        m_alm_on;
  alarm_code_t m_alm_code;
  logic        m_v_tank, m_v_out, m_v_pat;
  logic [7:0]  m_set_bpm;
  logic [15:0] m_set_tidal;

  result_t expected_q[$];
  int errors = 0;
  bit expect_given;
  result_t given_result;
  bit no_idle = 1'b0;

  task automatic model_reset();
    m_bpm_min = 12; m_bpm_max = 20; m_tid_min = 0; m_tid_max = 6; m_fill_ms = 200;
    m_phase = PH_FILL_TANK; m_tip = 0; m_since = 0;
    m_inh_lim = 1500; m_exh_lim = 3000; m_adj_lim = 300; m_target = 1280;
    m_max_cm = 50; m_low_cm = 0; m_peep_lim = 20;
    m_peak = 0; m_peak_prev = 20; m_peep = 0; m_rate = 0;
    m_alm_on = 0; m_alm_code = ALM_NONE;
    m_v_tank = 0; m_v_out = 0; m_v_pat = 0;
    m_set_bpm = 0; m_set_tidal = 0;
  endtask

  function automatic logic [31:0] pressure_cm(logic signed [15:0] raw);
    longint r;
    r = raw;
    if (r <= 0) return 0;
    return (r * 7037 + 12800) / 25600;
  endfunction

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic latch_knobs(tick_t t);
    int d, ci, ce;
    if (m_bpm_min <= t.bpm_knob && t.bpm_knob <= m_bpm_max) begin
      d = t.bpm_knob - m_bpm_min;
      ci = (125 * d + 1) / 2;
      ce = (375 * d + 1) / 2;
      m_inh_lim = ci >= 1500 ? 0 : 1500 - ci;
      m_exh_lim = ce >= 3000 ? 0 : 3000 - ce;
      m_set_bpm = t.bpm_knob;
    end
    if (m_tid_min <= t.tidal_knob && t.tidal_knob <= m_tid_max) begin
      m_adj_lim = 50 * t.tidal_knob;
      m_target = 1280 + 224 * t.tidal_knob;
      m_set_tidal = 400 + 100 * t.tidal_knob;
    end
    m_max_cm = t.high_airway_knob;
    m_low_cm = t.low_airway_knob;
    m_peep_lim = t.peep_knob;
  endtask

  task automatic advance_phase(tick_t t);
    logic [31:0] q;
    m_tip = 0;
    m_phase = phase_t'(m_phase + 2'd1);
    case (m_phase)
      PH_FILL_TANK: begin
        latch_knobs(t);
        {m_v_pat, m_v_out, m_v_tank} = 3'b011;
      end
      PH_FILL_ADJUST: {m_v_pat, m_v_out, m_v_tank} = 3'b011;
      PH_INHALE: begin
        m_peak_prev = m_peak;
        m_peak = 0;
        {m_v_pat, m_v_out, m_v_tank} = 3'b100;
        if (m_since == 0) m_rate = 99;
        else begin
          q = 60000 / m_since;
          m_rate = q > 99 ? 7'd99 : q[6:0];
        end
        m_since = 0;
        m_peep = 0;
      end
      default: {m_v_pat, m_v_out, m_v_tank} = 3'b010;
    endcase
  endtask

  // Compute the result of one tick and advance the predictor
  task automatic predict_tick(tick_t t, output result_t r);
    logic [31:0] cm, lim;
    longint pat, tank, sup;
    bit high;
    tank = t.tank_pressure; pat = t.patient_pressure; sup = t.supply_pressure;
    cm = pressure_cm(t.patient_pressure);
    m_since = add_sat32(m_since, t.elapsed_ms);
    if (cm > m_peak) m_peak = cm;
    if (m_peep > 0) begin
      if (cm < m_peep) m_peep = cm;
    end else m_peep = cm;
    m_tip = add_sat32(m_tip, t.elapsed_ms);
    case (m_phase)
      PH_FILL_TANK:   lim = m_fill_ms;
      PH_FILL_ADJUST: lim = m_adj_lim;
      PH_INHALE:      lim = m_inh_lim;
      default:        lim = m_exh_lim;
    endcase
    if (m_tip >= lim) advance_phase(t);
    else if (m_phase == PH_FILL_TANK) begin
      if (tank >= longint'(m_target)) advance_phase(t);
      if (sup <= 0) begin m_alm_on = 1; m_alm_code = ALM_SUPPLY; end
    end else if (m_phase == PH_FILL_ADJUST) begin
      if (tank >= longint'(m_target)) m_v_tank = 0;
    end else if (m_phase == PH_INHALE) begin
      high = pat * 70307 >= longint'(m_max_cm) * 256000;
      if (high) begin
        m_alm_on = 1; m_alm_code = ALM_PEAK_HIGH;
        advance_phase(t);
      end
      if (m_peak_prev <= m_low_cm) begin m_alm_on = 1; m_alm_code = ALM_PEAK_LOW; end
      if (m_peep >= m_peep_lim && m_peep > 0) begin
        m_alm_on = 1; m_alm_code = ALM_PEEP_HIGH;
      end
      if (m_peak_prev > m_low_cm && m_peep < m_peep_lim && !high && sup > 0) begin
        m_alm_on = 0; m_alm_code = ALM_NONE;
      end
    end
    r.phase = m_phase;
    r.tank_valve_open = m_v_tank;
    r.outlet_valve_open = m_v_out;
    r.patient_valve_open = m_v_pat;
    r.alarm_on = m_alm_on;
    r.alarm_code = m_alm_code;
    r.peak_cmh2o = m_peak[15:0];
    r.peep_cmh2o = m_peep[15:0];
    r.measured_bpm = m_rate;
    r.set_bpm = m_set_bpm;
    r.set_tidal_ml = m_set_tidal;
  endtask

  // Drive one request, holding until accepted
  task automatic send_tick(tick_t t);
    result_t r;
    while (!no_idle && $urandom_range(99) < 29) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    predict_tick(t, r);
    if (expect_given && r !== given_result) begin
      $error("directed row: expected %h, predictor %h", given_result, r);
      errors++;
    end
    expected_q.push_back(r);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_BPM_MIN:   m_bpm_min = val[7:0];
      REG_BPM_MAX:   m_bpm_max = val[7:0];
      REG_TIDAL_MIN: m_tid_min = val[7:0];
      REG_TIDAL_MAX: m_tid_max = val[7:0];
      default:       m_fill_ms = val;
    endcase
  endtask

  // Drop the request line and wait until every result is back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Random tick, mostly plausible pressures and small times
  function automatic tick_t random_tick();
    tick_t t;
    t.elapsed_ms = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(120));
    t.tank_pressure = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2800));
    t.patient_pressure = ($urandom_range(9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(5000));
    t.supply_pressure = ($urandom_range(15) == 0) ? 16'($urandom)
                        : 16'($urandom_range(30000, 1));
    t.bpm_knob = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(30, 8));
    t.tidal_knob = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
    t.high_airway_knob = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(70, 20));
    t.low_airway_knob = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(10));
    t.peep_knob = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(40, 5));
    return t;
  endfunction

  // Directed stimulus: elapsed, tank, patient, supply, knobs; expected result where obvious
  typedef struct {
    tick_t   t;
    bit      has_exp;
    result_t r;
  } row_t;
  row_t rows[$];

  function automatic tick_t mk(logic [15:0] e, logic [15:0] tk, logic [15:0] p, logic [15:0] s,
                               logic [7:0] b, logic [7:0] td, logic [7:0] h, logic [7:0] l,
                               logic [7:0] pe);
    tick_t t;
    t = '{e, tk, p, s, b, td, h, l, pe};
    return t;
  endfunction

  function automatic result_t mr(phase_t ph, logic [2:0] v, logic on, alarm_code_t c,
                                 logic [15:0] pk, logic [15:0] pp, logic [6:0] bpm,
                                 logic [7:0] sb, logic [15:0] st);
    result_t r;
    r = '{ph, v[0], v[1], v[2], on, c, pk, pp, bpm, sb, st};
    return r;
  endfunction

  initial begin
    // first tick after reset: nothing moves, negative pressures read as zero
    rows.push_back('{mk(0, 16'h8000, 16'h8000, 16'd100, 0, 0, 0, 0, 0), 1,
                     mr(PH_FILL_TANK, 3'b000, 0, ALM_NONE, 0, 0, 0, 0, 0)});
    // supply low in fill tank
    rows.push_back('{mk(1, 0, 0, 16'h0000, 0, 0, 0, 0, 0), 1,
                     mr(PH_FILL_TANK, 3'b000, 1, ALM_SUPPLY, 0, 0, 0, 0, 0)});
    // fill time reached: advance to fill adjust; knobs (bpm 12, tidal 6) are latched only on leaving exhale
    rows.push_back('{mk(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12, 6, 255, 255, 255), 0, '0});
    rows.push_back('{mk(0, 16'h7FFF, 0, 16'h8000, 8'hFF, 8'hFF, 0, 0, 0), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0100, 1, 20, 0, 50, 0, 20), 0, '0});
    rows.push_back('{mk(10, 0, 16'h7FFF, 1, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(0, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0200, 1, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(16'hFFFF, 16'h7FFF, 16'h0200, 1, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0100, 1, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(5, 0, 16'h0180, 1, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0080, 1, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(16'hFFFF, 16'h7FFF, 16'h0080, 16'h8000, 16, 3, 40, 5, 10), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0080, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0});
    rows.push_back('{mk(16'hFFFF, 0, 16'h0080, 1, 0, 0, 0, 0, 0), 0, '0});
  end

  // Result side: random stall, check against oldest prediction
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          automatic result_t e = expected_q.pop_front();
          automatic result_t a = res_ch.data;
          if (a.phase !== e.phase) begin
            $error("phase exp %0d got %0d", e.phase, a.phase); errors++; end
          if (a.tank_valve_open !== e.tank_valve_open) begin
            $error("tank_valve_open exp %0b got %0b", e.tank_valve_open, a.tank_valve_open);
            errors++; end
          if (a.outlet_valve_open !== e.outlet_valve_open) begin
            $error("outlet_valve_open exp %0b got %0b", e.outlet_valve_open,
                   a.outlet_valve_open); errors++; end
          if (a.patient_valve_open !== e.patient_valve_open) begin
            $error("patient_valve_open exp %0b got %0b", e.patient_valve_open,
                   a.patient_valve_open); errors++; end
          if (a.alarm_on !== e.alarm_on) begin
            $error("alarm_on exp %0b got %0b", e.alarm_on, a.alarm_on); errors++; end
          if (a.alarm_code !== e.alarm_code) begin
            $error("alarm_code exp %0d got %0d", e.alarm_code, a.alarm_code); errors++; end
          if (a.peak_cmh2o !== e.peak_cmh2o) begin
            $error("peak_cmh2o exp %0d got %0d", e.peak_cmh2o, a.peak_cmh2o); errors++; end
          if (a.peep_cmh2o !== e.peep_cmh2o) begin
            $error("peep_cmh2o exp %0d got %0d", e.peep_cmh2o, a.peep_cmh2o); errors++; end
          if (a.measured_bpm !== e.measured_bpm) begin
            $error("measured_bpm exp %0d got %0d", e.measured_bpm, a.measured_bpm);
            errors++; end
          if (a.set_bpm !== e.set_bpm) begin
            $error("set_bpm exp %0d got %0d", e.set_bpm, a.set_bpm); errors++; end
          if (a.set_tidal_ml !== e.set_tidal_ml) begin
            $error("set_tidal_ml exp %0d got %0d", e.set_tidal_ml, a.set_tidal_ml);
            errors++; end
        end
      end
      res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  // Main sequence
  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BPM_MIN;
    cfg_ch.wdata = '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      expect_given = rows[i].has_exp;
      given_result = rows[i].r;
      send_tick(rows[i].t);
    end
    expect_given = 1'b0;
    drain_results();

    // Phases of random ticks under several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_BPM_MIN, 0); write_reg(REG_BPM_MAX, 255);
                  write_reg(REG_TIDAL_MIN, 0); write_reg(REG_TIDAL_MAX, 255);
                  write_reg(REG_FILL_MS, 0); end
        1: begin write_reg(REG_BPM_MIN, 255); write_reg(REG_BPM_MAX, 0);
                  write_reg(REG_FILL_MS, 16'hFFFF); end
        2: begin write_reg(REG_BPM_MIN, 10); write_reg(REG_BPM_MAX, 25);
                  write_reg(REG_TIDAL_MIN, 1); write_reg(REG_TIDAL_MAX, 7);
                  write_reg(REG_FILL_MS, 150); end
        3: no_idle = 1'b1;
        4: begin no_idle = 1'b0; write_reg(REG_BPM_MIN, 0); write_reg(REG_BPM_MAX, 40);
                  write_reg(REG_FILL_MS, 50); end
        default: begin write_reg(REG_BPM_MIN, 12); write_reg(REG_BPM_MAX, 20);
                  write_reg(REG_TIDAL_MIN, 0); write_reg(REG_TIDAL_MAX, 6);
                  write_reg(REG_FILL_MS, 200); end
      endcase
      // drop the write line once the settings are in
      cfg_ch.valid <= 1'b0;
      for (int n = 0; n < 190; n++) begin
        send_tick(random_tick());
        // hold off until everything is back
        if (n == 95) drain_results();
      end
      drain_results();
    end

    if (errors == 0)
      $display("breath_cycle_sequencer verification clean");
    else
      $display("breath_cycle_sequencer verification failed");
    $finish;
  end

  // Timeout guard
  initial begin
    #20ms;
    $display("breath_cycle_sequencer verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bcs_pkg.sv
rtl/core/bcs_if.sv
rtl/core/bcs_ctrl.sv
rtl/core/bcs_dp.sv
rtl/core/breath_cycle_sequencer.sv
bench/tb_breath_cycle_sequencer.sv
